### rtl/bcd_date_time_setter_macros.svh
// Assertion macros shared by the date/time setter RTL.
// Depends on a clock named clock and a reset named reset in the using module.
`ifndef BCD_DATE_TIME_SETTER_MACROS_SVH
`define BCD_DATE_TIME_SETTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BDT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BDT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/bcd_dts_pkg.sv
// Types, codes and BCD helper functions for the date/time setter.
// No dependencies; used by the edit logic, the top level and the bench.
package bcd_dts_pkg;

   typedef enum logic [2:0] {
      POS_YEAR   = 3'd0,
      POS_MONTH  = 3'd1,
      POS_DAY    = 3'd2,
      POS_HOUR   = 3'd3,
      POS_MINUTE = 3'd4,
      POS_SECOND = 3'd5,
      POS_BACK   = 3'd6
   } focus_type;

   typedef enum logic [1:0] {
      KEY_UP    = 2'd0,
      KEY_DOWN  = 2'd1,
      KEY_LEFT  = 2'd2,
      KEY_RIGHT = 2'd3
   } key_type;

   typedef enum logic {
      MODE_KEY  = 1'b0,
      MODE_LOAD = 1'b1
   } mode_type;

   localparam logic [6:0] YEAR_MAX     = 7'd99;
   localparam logic [6:0] MONTH_MAX    = 7'd12;
   localparam logic [6:0] HOUR_MAX     = 7'd23;
   localparam logic [6:0] MINSEC_MAX   = 7'd59;
   localparam logic [6:0] DAYS_LONG    = 7'd31;
   localparam logic [6:0] DAYS_SHORT   = 7'd30;
   localparam logic [6:0] DAYS_FEB     = 7'd28;
   localparam logic [6:0] DAYS_FEB_LEAP = 7'd29;
   localparam logic [6:0] FIELD_MIN0   = 7'd0;
   localparam logic [6:0] FIELD_MIN1   = 7'd1;

   localparam logic [7:0] RST_YEAR   = 8'h00;
   localparam logic [4:0] RST_MONTH  = 5'h01;
   localparam logic [5:0] RST_DAY    = 6'h01;
   localparam logic [5:0] RST_HOUR   = 6'h00;
   localparam logic [6:0] RST_MINUTE = 7'h00;
   localparam logic [6:0] RST_SECOND = 7'h00;

   typedef struct packed {
      focus_type  focus;
      logic [7:0] year;
      logic [4:0] month;
      logic [5:0] day;
      logic [5:0] hour;
      logic [6:0] minute;
      logic [6:0] second;
   } state_type;

   typedef struct packed {
      mode_type   mode;
      logic       released;
      key_type    key;
      logic [7:0] load_year;
      logic [4:0] load_month;
      logic [5:0] load_day;
      logic [5:0] load_hour;
      logic [6:0] load_minute;
      logic [6:0] load_second;
   } req_item_type;

   typedef struct packed {
      logic       write_clock;
      logic       exit_request;
      focus_type  focus_now;
      focus_type  focus_before;
      logic       focus_moved;
      logic [7:0] out_year;
      logic [4:0] out_month;
      logic [5:0] out_day;
      logic [5:0] out_hour;
      logic [6:0] out_minute;
      logic [6:0] out_second;
   } rsp_item_type;

   // Packed BCD to binary; digits above 9 are taken at face value.
   function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
      return ({4'b0000, v[7:4]} * 8'd10) + {4'b0000, v[3:0]};
   endfunction

   // Binary (0-99) to packed BCD; tens by reciprocal multiply (205 / 2048).
   function automatic logic [7:0] bin_to_bcd(input logic [6:0] z);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  rem;
      prod = {8'b0, z} * 15'd205;
      tens = prod[14:11];
      rem  = z - 7'({3'b000, tens} * 7'd10);
      return {tens, rem[3:0]};
   endfunction

   // Step a BCD field by one inside [lo, hi], wrapping at both ends.
   function automatic logic [7:0] bcd_step(input logic [7:0] v, input logic up,
                                           input logic [6:0] lo, input logic [6:0] hi);
      logic [7:0] z;
      logic [7:0] lo8;
      logic [7:0] hi8;
      z   = bcd_to_bin(v);
      lo8 = {1'b0, lo};
      hi8 = {1'b0, hi};
      if (up) begin
         z = z + 8'd1;
         if (z > hi8) z = lo8;
      end else if (z <= lo8) begin
         z = hi8;
      end else begin
         z = z - 8'd1;
         if (z > hi8) z = lo8;
      end
      return bin_to_bcd(z[6:0]);
   endfunction

endpackage

### rtl/bcd_dts_if.sv
// Valid/ready channel interfaces for the date/time setter.
// Does not reference bcd_dts_pkg; its field widths are kept in step with it.
interface bcd_dts_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic       released;
   logic [1:0] key;
   logic [7:0] load_year;
   logic [4:0] load_month;
   logic [5:0] load_day;
   logic [5:0] load_hour;
   logic [6:0] load_minute;
   logic [6:0] load_second;

   modport source (output valid, mode, released, key, load_year, load_month, load_day,
                   load_hour, load_minute, load_second, input ready);
   modport sink   (input valid, mode, released, key, load_year, load_month, load_day,
                   load_hour, load_minute, load_second, output ready);
endinterface

interface bcd_dts_rsp_if;
   logic       valid;
   logic       ready;
   logic       write_clock;
   logic       exit_request;
   logic [2:0] focus_now;
   logic [2:0] focus_before;
   logic       focus_moved;
   logic [7:0] out_year;
   logic [4:0] out_month;
   logic [5:0] out_day;
   logic [5:0] out_hour;
   logic [6:0] out_minute;
   logic [6:0] out_second;

   modport source (output valid, write_clock, exit_request, focus_now, focus_before,
                   focus_moved, out_year, out_month, out_day, out_hour, out_minute,
                   out_second, input ready);
   modport sink   (input valid, write_clock, exit_request, focus_now, focus_before,
                   focus_moved, out_year, out_month, out_day, out_hour, out_minute,
                   out_second, output ready);
endinterface

### rtl/bcd_dts_edit.sv
// Next-state and result logic for one item of the date/time setter.
// Depends on bcd_dts_pkg (types, field limits, BCD step function).
module bcd_dts_edit (
   input  bcd_dts_pkg::state_type    cur,
   input  bcd_dts_pkg::req_item_type item,
   output bcd_dts_pkg::state_type    nxt,
   output bcd_dts_pkg::rsp_item_type res
);

   logic       up;
   logic [7:0] year_bin;
   logic [7:0] month_bin;
   logic [6:0] month_len;
   logic       write_clock;
   logic       exit_request;
   logic       moved;

   assign up = (item.key == bcd_dts_pkg::KEY_UP);

   // Month length; leap year when the binary year is a multiple of four.
   always_comb begin
      year_bin  = bcd_dts_pkg::bcd_to_bin(cur.year);
      month_bin = bcd_dts_pkg::bcd_to_bin({3'b000, cur.month});
      case (month_bin)
         8'd2:    month_len = (year_bin[1:0] == 2'b00) ? bcd_dts_pkg::DAYS_FEB_LEAP
                                                      : bcd_dts_pkg::DAYS_FEB;
         8'd4, 8'd6, 8'd9, 8'd11: month_len = bcd_dts_pkg::DAYS_SHORT;
         default: month_len = bcd_dts_pkg::DAYS_LONG;
      endcase
   end

   always_comb begin
      nxt          = cur;
      write_clock  = 1'b0;
      exit_request = 1'b0;
      moved        = 1'b0;
      if (item.mode == bcd_dts_pkg::MODE_LOAD) begin
         nxt.year   = item.load_year;
         nxt.month  = item.load_month;
         nxt.day    = item.load_day;
         nxt.hour   = item.load_hour;
         nxt.minute = item.load_minute;
         nxt.second = item.load_second;
      end else if (item.released) begin
         case (item.key)
            bcd_dts_pkg::KEY_RIGHT: begin
               moved     = 1'b1;
               nxt.focus = (cur.focus >= bcd_dts_pkg::POS_BACK)
                           ? bcd_dts_pkg::POS_YEAR
                           : bcd_dts_pkg::focus_type'(cur.focus + 3'd1);
            end
            bcd_dts_pkg::KEY_LEFT: begin
               moved     = 1'b1;
               nxt.focus = (cur.focus == bcd_dts_pkg::POS_YEAR ||
                            cur.focus > bcd_dts_pkg::POS_BACK)
                           ? bcd_dts_pkg::POS_BACK
                           : bcd_dts_pkg::focus_type'(cur.focus - 3'd1);
            end
            default: begin
               if (cur.focus >= bcd_dts_pkg::POS_BACK) begin
                  exit_request = 1'b1;
               end else begin
                  write_clock = 1'b1;
                  case (cur.focus)
                     bcd_dts_pkg::POS_YEAR:
                        nxt.year = bcd_dts_pkg::bcd_step(cur.year, up,
                           bcd_dts_pkg::FIELD_MIN0, bcd_dts_pkg::YEAR_MAX);
                     bcd_dts_pkg::POS_MONTH:
                        nxt.month = 5'(bcd_dts_pkg::bcd_step({3'b000, cur.month}, up,
                           bcd_dts_pkg::FIELD_MIN1, bcd_dts_pkg::MONTH_MAX));
                     bcd_dts_pkg::POS_DAY:
                        nxt.day = 6'(bcd_dts_pkg::bcd_step({2'b00, cur.day}, up,
                           bcd_dts_pkg::FIELD_MIN1, month_len));
                     bcd_dts_pkg::POS_HOUR:
                        nxt.hour = 6'(bcd_dts_pkg::bcd_step({2'b00, cur.hour}, up,
                           bcd_dts_pkg::FIELD_MIN0, bcd_dts_pkg::HOUR_MAX));
                     bcd_dts_pkg::POS_MINUTE:
                        nxt.minute = 7'(bcd_dts_pkg::bcd_step({1'b0, cur.minute}, up,
                           bcd_dts_pkg::FIELD_MIN0, bcd_dts_pkg::MINSEC_MAX));
                     default:
                        nxt.second = 7'(bcd_dts_pkg::bcd_step({1'b0, cur.second}, up,
                           bcd_dts_pkg::FIELD_MIN0, bcd_dts_pkg::MINSEC_MAX));
                  endcase
               end
            end
         endcase
      end
   end

   always_comb begin
      res.write_clock  = write_clock;
      res.exit_request = exit_request;
      res.focus_now    = nxt.focus;
      res.focus_before = cur.focus;
      res.focus_moved  = moved;
      res.out_year     = nxt.year;
      res.out_month    = nxt.month;
      res.out_day      = nxt.day;
      res.out_hour     = nxt.hour;
      res.out_minute   = nxt.minute;
      res.out_second   = nxt.second;
   end

endmodule

### rtl/bcd_date_time_setter.sv
// Top level of the BCD date/time setter: input register, edit logic, result register.
// Depends on bcd_dts_pkg, bcd_dts_if, bcd_dts_edit and the assertion macro header.
//
//   channel    direction  carries
//   req_chan   in         mode, released, key, six BCD load values
//   rsp_chan   out        flags, focus before/after, six current BCD fields
//
// Sustained rate is one item per cycle while rsp_chan is not stalled; each item passes
// through the input register and then the result register before its rsp transfer.
// The item waits in the input register, then the edit logic updates
// the date/time state and fills the result register in the same edge.
// A stall on rsp_chan holds the result register; the input register still
// takes one more item, so req_chan.ready drops only when both are full.
// Reset (synchronous) sets focus to year and the fields to 00-01-01 00:00:00.
`include "bcd_date_time_setter_macros.svh"

module bcd_date_time_setter (
   input  logic                 clock,
   input  logic                 reset,
   bcd_dts_req_if.sink          req_chan,
   bcd_dts_rsp_if.source        rsp_chan
);

   bcd_dts_pkg::req_item_type req_ff;
   bcd_dts_pkg::req_item_type req_in;
   logic                      s1_valid_ff;
   logic                      s1_valid_in;

   bcd_dts_pkg::rsp_item_type rsp_ff;
   bcd_dts_pkg::rsp_item_type rsp_in;
   logic                      s2_valid_ff;
   logic                      s2_valid_in;

   bcd_dts_pkg::state_type    state_ff;
   bcd_dts_pkg::state_type    state_in;
   bcd_dts_pkg::state_type    edit_state;
   bcd_dts_pkg::rsp_item_type edit_rsp;

   logic req_xfer;
   logic s2_free;
   logic commit;

   // Result register can take a new item when empty or being drained.
   assign s2_free  = !s2_valid_ff || rsp_chan.ready;
   assign commit   = s1_valid_ff && s2_free;
   assign req_chan.ready = !s1_valid_ff || s2_free;
   assign req_xfer = req_chan.valid && req_chan.ready;

   // Capture the incoming item on a transfer.
   always_comb begin
      req_in.mode        = bcd_dts_pkg::mode_type'(req_chan.mode);
      req_in.released    = req_chan.released;
      req_in.key         = bcd_dts_pkg::key_type'(req_chan.key);
      req_in.load_year   = req_chan.load_year;
      req_in.load_month  = req_chan.load_month;
      req_in.load_day    = req_chan.load_day;
      req_in.load_hour   = req_chan.load_hour;
      req_in.load_minute = req_chan.load_minute;
      req_in.load_second = req_chan.load_second;
   end

   bcd_dts_edit u_edit (
      .cur  (state_ff),
      .item (req_ff),
      .nxt  (edit_state),
      .res  (edit_rsp)
   );

   // Advance state and result only when the item moves to the result register.
   always_comb begin
      state_in    = commit ? edit_state : state_ff;
      rsp_in      = commit ? edit_rsp : rsp_ff;
      s1_valid_in = req_xfer ? 1'b1 : (commit ? 1'b0 : s1_valid_ff);
      s2_valid_in = commit ? 1'b1 : (rsp_chan.ready ? 1'b0 : s2_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         state_ff.focus  <= bcd_dts_pkg::POS_YEAR;
         state_ff.year   <= bcd_dts_pkg::RST_YEAR;
         state_ff.month  <= bcd_dts_pkg::RST_MONTH;
         state_ff.day    <= bcd_dts_pkg::RST_DAY;
         state_ff.hour   <= bcd_dts_pkg::RST_HOUR;
         state_ff.minute <= bcd_dts_pkg::RST_MINUTE;
         state_ff.second <= bcd_dts_pkg::RST_SECOND;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         state_ff    <= state_in;
      end
   end

   // Payload registers: no reset.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_ff <= req_in;
      end
      rsp_ff <= rsp_in;
   end

   // Drive the result channel from the result register.
   assign rsp_chan.valid        = s2_valid_ff;
   assign rsp_chan.write_clock  = rsp_ff.write_clock;
   assign rsp_chan.exit_request = rsp_ff.exit_request;
   assign rsp_chan.focus_now    = rsp_ff.focus_now;
   assign rsp_chan.focus_before = rsp_ff.focus_before;
   assign rsp_chan.focus_moved  = rsp_ff.focus_moved;
   assign rsp_chan.out_year     = rsp_ff.out_year;
   assign rsp_chan.out_month    = rsp_ff.out_month;
   assign rsp_chan.out_day      = rsp_ff.out_day;
   assign rsp_chan.out_hour     = rsp_ff.out_hour;
   assign rsp_chan.out_minute   = rsp_ff.out_minute;
   assign rsp_chan.out_second   = rsp_ff.out_second;

   // At most one of edit, exit and move per result.
   `BDT_ASSERT_NOW(a_flags_exclusive, s2_valid_ff,
      $onehot0({rsp_ff.write_clock, rsp_ff.exit_request, rsp_ff.focus_moved}),
      "more than one result flag set")
   // Focus changes only through a move.
   `BDT_ASSERT_NOW(a_focus_only_on_move, s2_valid_ff && !rsp_ff.focus_moved,
      rsp_ff.focus_now == rsp_ff.focus_before, "focus changed without a move")
   // The committed result mirrors the stored date/time state.
   `BDT_ASSERT_NEXT(a_result_matches_state, commit,
      rsp_ff.focus_now == state_ff.focus && rsp_ff.out_year == state_ff.year &&
      rsp_ff.out_month == state_ff.month && rsp_ff.out_day == state_ff.day &&
      rsp_ff.out_hour == state_ff.hour && rsp_ff.out_minute == state_ff.minute &&
      rsp_ff.out_second == state_ff.second, "result register out of step with state")
   // A stalled result leaves the date/time state alone.
   `BDT_ASSERT_NEXT(a_state_holds_on_stall, s2_valid_ff && !rsp_chan.ready,
      $stable(state_ff), "state changed while the result was stalled")

endmodule

### bench/bcd_dts_checker.sv
// Checker for the BCD date/time setter: watches both channels, models the edit
// behavior and compares each result transfer. Depends on bcd_dts_pkg and bcd_dts_if.
module bcd_dts_checker (
   input  logic   clock,
   input  logic   reset,
   bcd_dts_req_if req_mon,
   bcd_dts_rsp_if rsp_mon,
   output int     fail_count,
   output int     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // Modeled editor state.
   bcd_dts_pkg::focus_type cur_focus = bcd_dts_pkg::POS_YEAR;
   logic [7:0] cur_year   = bcd_dts_pkg::RST_YEAR;
   logic [4:0] cur_month  = bcd_dts_pkg::RST_MONTH;
   logic [5:0] cur_day    = bcd_dts_pkg::RST_DAY;
   logic [5:0] cur_hour   = bcd_dts_pkg::RST_HOUR;
   logic [6:0] cur_minute = bcd_dts_pkg::RST_MINUTE;
   logic [6:0] cur_second = bcd_dts_pkg::RST_SECOND;

   bcd_dts_pkg::rsp_item_type due_readouts[$];
   int           mismatches    = 0;
   int           pending_count = 0;

   assign fail_count  = mismatches;
   assign outstanding = pending_count;

   function automatic int bcd_value(input logic [7:0] v);
      return int'(v[7:4]) * 10 + int'(v[3:0]);
   endfunction

   function automatic logic [7:0] bcd_of(input int z);
      logic [3:0] tens;
      logic [3:0] units;
      tens  = 4'(z / 10);
      units = 4'(z % 10);
      return {tens, units};
   endfunction

   // One step up or down inside [lo, hi]; digits above 9 count at face value.
   function automatic logic [7:0] bcd_wrap(input logic [7:0] v, input bit up,
                                           input int lo, input int hi);
      int z;
      z = bcd_value(v);
      if (up) begin
         z = (z + 1 > hi) ? lo : z + 1;
      end else if (z <= lo) begin
         z = hi;
      end else begin
         z = (z - 1 > hi) ? lo : z - 1;
      end
      return bcd_of(z);
   endfunction

   function automatic int month_days();
      int m;
      m = bcd_value({3'b000, cur_month});
      if (m == 2) begin
         return (bcd_value(cur_year) % 4 == 0) ? int'(bcd_dts_pkg::DAYS_FEB_LEAP)
                                               : int'(bcd_dts_pkg::DAYS_FEB);
      end
      if (m == 4 || m == 6 || m == 9 || m == 11) return int'(bcd_dts_pkg::DAYS_SHORT);
      return int'(bcd_dts_pkg::DAYS_LONG);
   endfunction

   // Apply one accepted item to the modeled state and return the readout it causes.
   function automatic bcd_dts_pkg::rsp_item_type edit_clock(
      input bcd_dts_pkg::req_item_type it);
      bcd_dts_pkg::rsp_item_type r;
      bit                        up;
      r = '0;
      r.focus_before = cur_focus;
      if (it.mode == bcd_dts_pkg::MODE_LOAD) begin
         cur_year   = it.load_year;
         cur_month  = it.load_month;
         cur_day    = it.load_day;
         cur_hour   = it.load_hour;
         cur_minute = it.load_minute;
         cur_second = it.load_second;
      end else if (it.released) begin
         case (it.key)
            bcd_dts_pkg::KEY_RIGHT: begin
               cur_focus = (cur_focus >= bcd_dts_pkg::POS_BACK) ? bcd_dts_pkg::POS_YEAR
                           : bcd_dts_pkg::focus_type'(cur_focus + 3'd1);
               r.focus_moved = 1'b1;
            end
            bcd_dts_pkg::KEY_LEFT: begin
               cur_focus = (cur_focus == bcd_dts_pkg::POS_YEAR ||
                            cur_focus > bcd_dts_pkg::POS_BACK)
                           ? bcd_dts_pkg::POS_BACK
                           : bcd_dts_pkg::focus_type'(cur_focus - 3'd1);
               r.focus_moved = 1'b1;
            end
            default: begin
               if (cur_focus >= bcd_dts_pkg::POS_BACK) begin
                  r.exit_request = 1'b1;
               end else begin
                  up = (it.key == bcd_dts_pkg::KEY_UP);
                  case (cur_focus)
                     bcd_dts_pkg::POS_YEAR:
                        cur_year = bcd_wrap(cur_year, up, int'(bcd_dts_pkg::FIELD_MIN0),
                                            int'(bcd_dts_pkg::YEAR_MAX));
                     bcd_dts_pkg::POS_MONTH:
                        cur_month = 5'(bcd_wrap({3'b000, cur_month}, up,
                           int'(bcd_dts_pkg::FIELD_MIN1), int'(bcd_dts_pkg::MONTH_MAX)));
                     bcd_dts_pkg::POS_DAY:
                        cur_day = 6'(bcd_wrap({2'b00, cur_day}, up,
                           int'(bcd_dts_pkg::FIELD_MIN1), month_days()));
                     bcd_dts_pkg::POS_HOUR:
                        cur_hour = 6'(bcd_wrap({2'b00, cur_hour}, up,
                           int'(bcd_dts_pkg::FIELD_MIN0), int'(bcd_dts_pkg::HOUR_MAX)));
                     bcd_dts_pkg::POS_MINUTE:
                        cur_minute = 7'(bcd_wrap({1'b0, cur_minute}, up,
                           int'(bcd_dts_pkg::FIELD_MIN0), int'(bcd_dts_pkg::MINSEC_MAX)));
                     default:
                        cur_second = 7'(bcd_wrap({1'b0, cur_second}, up,
                           int'(bcd_dts_pkg::FIELD_MIN0), int'(bcd_dts_pkg::MINSEC_MAX)));
                  endcase
                  r.write_clock = 1'b1;
               end
            end
         endcase
      end
      r.focus_now  = cur_focus;
      r.out_year   = cur_year;
      r.out_month  = cur_month;
      r.out_day    = cur_day;
      r.out_hour   = cur_hour;
      r.out_minute = cur_minute;
      r.out_second = cur_second;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      bcd_dts_pkg::req_item_type seen;
      bcd_dts_pkg::rsp_item_type want;
      if (reset) begin
         cur_focus  = bcd_dts_pkg::POS_YEAR;
         cur_year   = bcd_dts_pkg::RST_YEAR;
         cur_month  = bcd_dts_pkg::RST_MONTH;
         cur_day    = bcd_dts_pkg::RST_DAY;
         cur_hour   = bcd_dts_pkg::RST_HOUR;
         cur_minute = bcd_dts_pkg::RST_MINUTE;
         cur_second = bcd_dts_pkg::RST_SECOND;
         due_readouts.delete();
      end else begin
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            seen = bcd_dts_pkg::req_item_type'({req_mon.mode, req_mon.released,
                      req_mon.key, req_mon.load_year, req_mon.load_month,
                      req_mon.load_day, req_mon.load_hour, req_mon.load_minute,
                      req_mon.load_second});
            due_readouts.push_back(edit_clock(seen));
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (due_readouts.size() == 0) begin
               $error("result transfer with no item pending");
               mismatches++;
            end else begin
               want = due_readouts.pop_front();
               compare_field("write_clock", 8'(want.write_clock), 8'(rsp_mon.write_clock));
               compare_field("exit_request", 8'(want.exit_request),
                             8'(rsp_mon.exit_request));
               compare_field("focus_now", 8'(want.focus_now), 8'(rsp_mon.focus_now));
               compare_field("focus_before", 8'(want.focus_before),
                             8'(rsp_mon.focus_before));
               compare_field("focus_moved", 8'(want.focus_moved), 8'(rsp_mon.focus_moved));
               compare_field("out_year", want.out_year, rsp_mon.out_year);
               compare_field("out_month", 8'(want.out_month), 8'(rsp_mon.out_month));
               compare_field("out_day", 8'(want.out_day), 8'(rsp_mon.out_day));
               compare_field("out_hour", 8'(want.out_hour), 8'(rsp_mon.out_hour));
               compare_field("out_minute", 8'(want.out_minute), 8'(rsp_mon.out_minute));
               compare_field("out_second", 8'(want.out_second), 8'(rsp_mon.out_second));
            end
         end
      end
      pending_count = due_readouts.size();
   end

endmodule

### bench/bcd_date_time_setter_tb.sv
// Top of the testbench for the BCD date/time setter: clock, reset, stimulus and verdict.
// Depends on bcd_dts_pkg, bcd_dts_if, the block itself and bcd_dts_checker.
module bcd_date_time_setter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 750;
   localparam int RUN_LIMIT_NS = 2_000_000;
   localparam int DRAIN_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   outstanding;

   // Percent chance of a gap before a transfer (sender) or of a stall (receiver).
   int gap_pct   = 0;
   int stall_pct = 0;

   bcd_dts_req_if req_chan();
   bcd_dts_rsp_if rsp_chan();

   bcd_date_time_setter u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bcd_dts_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // 2 ns clock.
   initial begin
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #(RUN_LIMIT_NS);
      $display("bcd_date_time_setter_tb: FAIL");
      $finish;
   end

   // Idle length: drawn from three ranges, the shortest most often and the longest rarely.
   function automatic int idle_length();
      int r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(2, 1);
      if (r < 93) return $urandom_range(8, 3);
      return $urandom_range(60, 20);
   endfunction

   // Load item with every field anywhere in its range, including non-decimal digits.
   function automatic bcd_dts_pkg::req_item_type raw_load();
      bcd_dts_pkg::req_item_type it;
      it.mode        = bcd_dts_pkg::MODE_LOAD;
      it.released    = 1'($urandom_range(1));
      it.key         = bcd_dts_pkg::key_type'(2'($urandom_range(3)));
      it.load_year   = 8'($urandom_range(153));
      it.load_month  = 5'($urandom_range(18));
      it.load_day    = 6'($urandom_range(49));
      it.load_hour   = 6'($urandom_range(35));
      it.load_minute = 7'($urandom_range(89));
      it.load_second = 7'($urandom_range(89));
      return it;
   endfunction

   // Key event; the load fields carry noise the block must ignore.
   function automatic bcd_dts_pkg::req_item_type key_item(input bcd_dts_pkg::key_type k,
                                                          input logic rel);
      bcd_dts_pkg::req_item_type it;
      it          = raw_load();
      it.mode     = bcd_dts_pkg::MODE_KEY;
      it.released = rel;
      it.key      = k;
      return it;
   endfunction

   function automatic bcd_dts_pkg::req_item_type load_item(
      input logic [7:0] y, input logic [4:0] mo, input logic [5:0] d,
      input logic [5:0] h, input logic [6:0] mi, input logic [6:0] s);
      bcd_dts_pkg::req_item_type it;
      it             = raw_load();
      it.load_year   = y;
      it.load_month  = mo;
      it.load_day    = d;
      it.load_hour   = h;
      it.load_minute = mi;
      it.load_second = s;
      return it;
   endfunction

   // Decimal value in [lo, hi] as packed BCD, leaning toward the wrap points.
   function automatic logic [7:0] bcd_pick(input int lo, input int hi);
      int z;
      case ($urandom_range(9))
         0:       z = lo;
         1:       z = hi;
         2:       z = $urandom_range(hi, hi - 3);
         default: z = $urandom_range(hi, lo);
      endcase
      return 8'(((z / 10) << 4) | (z % 10));
   endfunction

   // Well-formed calendar load; the ends of each field's range come up often.
   function automatic bcd_dts_pkg::req_item_type calendar_load();
      return load_item(bcd_pick(0, 99), 5'(bcd_pick(1, 12)), 6'(bcd_pick(1, 31)),
                       6'(bcd_pick(0, 23)), 7'(bcd_pick(0, 59)), 7'(bcd_pick(0, 59)));
   endfunction

   // Present one item at the falling edge and hold it until a rising edge transfers it.
   // Valid stays high between back-to-back items, so it is never dropped and raised
   // within one time step.
   task automatic send_item(input bcd_dts_pkg::req_item_type it);
      if ($urandom_range(99) < gap_pct) begin
         req_chan.valid = 1'b0;
         repeat (idle_length()) @(negedge clock);
      end
      req_chan.valid       = 1'b1;
      req_chan.mode        = it.mode;
      req_chan.released    = it.released;
      req_chan.key         = it.key;
      req_chan.load_year   = it.load_year;
      req_chan.load_month  = it.load_month;
      req_chan.load_day    = it.load_day;
      req_chan.load_hour   = it.load_hour;
      req_chan.load_minute = it.load_minute;
      req_chan.load_second = it.load_second;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   // Result side: drop ready for random stretches, hold it high otherwise.
   initial begin
      int hold;
      hold = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_chan.ready = 1'b0;
            hold--;
         end else if ($urandom_range(99) < stall_pct) begin
            rsp_chan.ready = 1'b0;
            hold = idle_length() - 1;
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   initial begin
      int                   counted;
      int                   pick;
      int                   run;
      bit                   quiet;
      bcd_dts_pkg::key_type k;

      // Drive every input to a known value before reset lifts.
      req_chan.valid       = 1'b0;
      req_chan.mode        = bcd_dts_pkg::MODE_KEY;
      req_chan.released    = 1'b0;
      req_chan.key         = bcd_dts_pkg::KEY_UP;
      req_chan.load_year   = '0;
      req_chan.load_month  = '0;
      req_chan.load_day    = '0;
      req_chan.load_hour   = '0;
      req_chan.load_minute = '0;
      req_chan.load_second = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part; focus starts on the year.
      gap_pct   = 30;
      stall_pct = 30;
      send_item(key_item(bcd_dts_pkg::KEY_UP, 1'b0));      // press only: nothing changes
      send_item(key_item(bcd_dts_pkg::KEY_UP, 1'b1));      // year 00 -> 01
      send_item(key_item(bcd_dts_pkg::KEY_DOWN, 1'b1));    // back to 00
      send_item(key_item(bcd_dts_pkg::KEY_DOWN, 1'b1));    // wrap below: 99
      send_item(key_item(bcd_dts_pkg::KEY_UP, 1'b1));      // wrap above: 00
      send_item(key_item(bcd_dts_pkg::KEY_LEFT, 1'b1));    // year -> back, wrapping left
      send_item(key_item(bcd_dts_pkg::KEY_UP, 1'b1));      // exit request, nothing edited
      send_item(key_item(bcd_dts_pkg::KEY_DOWN, 1'b1));    // exit request again
      send_item(key_item(bcd_dts_pkg::KEY_RIGHT, 1'b1));   // back -> year, wrapping right

      // Leap February: day wraps at 29.
      send_item(load_item(8'h24, 5'h02, 6'h29, 6'h23, 7'h59, 7'h59));
      send_item(key_item(bcd_dts_pkg::KEY_RIGHT, 1'b1));
      send_item(key_item(bcd_dts_pkg::KEY_RIGHT, 1'b1));   // focus on day
      send_item(key_item(bcd_dts_pkg::KEY_UP, 1'b1));      // 29 -> 01
      send_item(key_item(bcd_dts_pkg::KEY_DOWN, 1'b1));    // 01 -> 29

      // Plain February: day wraps at 28; focus is kept across the load.
      send_item(load_item(8'h23, 5'h02, 6'h28, 6'h00, 7'h00, 7'h00));
      send_item(key_item(bcd_dts_pkg::KEY_UP, 1'b1));
      send_item(key_item(bcd_dts_pkg::KEY_DOWN, 1'b1));

      // Non-decimal digits everywhere; month 15 counts as a 31-day month.
      send_item(load_item(8'h8F, 5'h0F, 6'h2F, 6'h1F, 7'h4F, 7'h4F));
      send_item(key_item(bcd_dts_pkg::KEY_UP, 1'b1));      // day 35 past the top -> 01
      send_item(key_item(bcd_dts_pkg::KEY_LEFT, 1'b1));    // focus on month
      send_item(key_item(bcd_dts_pkg::KEY_UP, 1'b1));      // month 15 -> 01

      // Field extremes; month 00 steps down to 12, day 00 is left as is.
      send_item(load_item(8'h99, 5'h00, 6'h00, 6'h23, 7'h59, 7'h59));
      send_item(key_item(bcd_dts_pkg::KEY_DOWN, 1'b1));
      send_item(key_item(bcd_dts_pkg::KEY_LEFT, 1'b1));    // focus on year
      send_item(key_item(bcd_dts_pkg::KEY_UP, 1'b1));      // 99 -> 00

      // Random part: mostly runs of up/down edits with loads and moves between them,
      // some raw loads and ignored presses as noise.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         // Alternate stretches with no idling against stretches with heavy idling.
         quiet     = (counted % 200) < 50;
         gap_pct   = quiet ? 0 : 35;
         stall_pct = quiet ? 0 : 35;
         pick = $urandom_range(99);
         if (pick < 15) begin
            if ($urandom_range(4) == 0) send_item(raw_load());
            else send_item(calendar_load());
            counted++;
         end else if (pick < 70) begin
            k   = ($urandom_range(1) == 1) ? bcd_dts_pkg::KEY_UP : bcd_dts_pkg::KEY_DOWN;
            run = $urandom_range(12, 1);
            repeat (run) send_item(key_item(k, 1'b1));
            counted += run;
         end else if (pick < 90) begin
            k = ($urandom_range(1) == 1) ? bcd_dts_pkg::KEY_LEFT : bcd_dts_pkg::KEY_RIGHT;
            send_item(key_item(k, 1'b1));
            counted++;
         end else begin
            send_item(key_item(bcd_dts_pkg::key_type'(2'($urandom_range(3))), 1'b0));
         end
      end

      // Drain: wait for every expected result, then wait out DRAIN_CYCLES for strays.
      req_chan.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("bcd_date_time_setter_tb: PASS");
      end else begin
         $display("bcd_date_time_setter_tb: FAIL");
      end
      $finish;
   end

endmodule
